### design/dwop_pkg.sv
// Shared types and constants for the depth window obstacle power block.
// No dependencies; every other design file imports this package.
package dwop_pkg;

    localparam int COORD_BITS = 11;
    localparam int DEPTH_BITS = 16;

    localparam int LIMIT_W = 16;
    localparam int CSTART_W = 11;
    localparam int CEND_W = 12;
    localparam int COUNT_W = 23;
    localparam int POWER_W = 7;

    // coordinates and window bounds are compared at this width
    localparam int CMP_W = (COORD_BITS >= CEND_W) ? COORD_BITS + 1 : CEND_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [POWER_W-1:0] POWER_BASE = 7'd30;
    localparam int POWER_SPAN = 70;

    // quotient of 70*(limit-min)/limit stays below 2^QUO_W
    localparam int QUO_W = 7;
    localparam int NUM_W = LIMIT_W + QUO_W;
    localparam int DSR_W = LIMIT_W + QUO_W - 1;
    localparam int STEP_W = $clog2(QUO_W);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [LIMIT_W-1:0] RST_NEAR_LIMIT = 16'd2000;
    localparam logic [CSTART_W-1:0] RST_COL_START = 11'd0;
    localparam logic [CEND_W-1:0] RST_COL_END = 12'd2048;
    localparam logic [CSTART_W-1:0] RST_ROW_START = 11'd0;
    localparam logic [CEND_W-1:0] RST_ROW_END = 12'd2048;
    localparam logic [COUNT_W-1:0] RST_COUNT_NEEDED = 23'd0;

    typedef enum logic [2:0] {
        REG_NEAR_LIMIT = 3'd0,
        REG_COL_START = 3'd1,
        REG_COL_END = 3'd2,
        REG_ROW_START = 3'd3,
        REG_ROW_END = 3'd4,
        REG_COUNT_NEEDED = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [LIMIT_W-1:0] near_limit;
        logic [CSTART_W-1:0] col_start;
        logic [CEND_W-1:0] col_end;
        logic [CSTART_W-1:0] row_start;
        logic [CEND_W-1:0] row_end;
        logic [COUNT_W-1:0] count_needed;
    } t_cfg;

    // summary of one finished frame, handed from front to back
    typedef struct packed {
        logic seen;
        logic [LIMIT_W-1:0] min_depth;
        logic [LIMIT_W-1:0] near_limit;
    } t_frame_sum;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

    typedef struct packed {
        logic pop;
        logic empty;
    } t_q_rd;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV = 2'd1,
        BK_DONE = 2'd2
    } t_back_state;

endpackage

### design/dwop_intf.sv
// Valid/ready stream interfaces for pixel requests and frame results.
// Depends on dwop_pkg for field widths.
interface dwop_pix_if;
    import dwop_pkg::*;

    logic valid;
    logic ready;
    logic [DEPTH_BITS-1:0] depth_raw;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic last_pixel;

    modport source (output valid, depth_raw, col, row, last_pixel, input ready);
    modport sink (input valid, depth_raw, col, row, last_pixel, output ready);
endinterface

interface dwop_res_if;
    import dwop_pkg::*;

    logic valid;
    logic ready;
    logic [LIMIT_W-1:0] nearest_depth;
    logic [POWER_W-1:0] motor_power;
    logic object_seen;

    modport source (output valid, nearest_depth, motor_power, object_seen, input ready);
    modport sink (input valid, nearest_depth, motor_power, object_seen, output ready);
endinterface

### design/dwop_front.sv
// Front end: classifies each pixel against the window and near limit,
// keeps the frame count and minimum, and pushes a summary at frame end.
// Depends on dwop_pkg.
module dwop_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dwop_pkg::t_cfg             i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [dwop_pkg::DEPTH_BITS-1:0] i_depth_raw,
    input  logic [dwop_pkg::COORD_BITS-1:0] i_col,
    input  logic [dwop_pkg::COORD_BITS-1:0] i_row,
    input  logic                       i_last_pixel,
    output dwop_pkg::t_q_wr            o_qw,
    input  logic                       i_q_full,
    output dwop_pkg::t_frame_sum       o_sum
);
    import dwop_pkg::*;

    logic [COUNT_W-1:0] r_count, n_count;
    logic [LIMIT_W-1:0] r_min, n_min;
    logic [LIMIT_W-1:0] depth_ext;
    logic in_window, near, accept;

    assign o_ready = !i_q_full;
    assign accept = i_valid && o_ready;
    assign depth_ext = LIMIT_W'(i_depth_raw);

    always_comb begin
        in_window = (CMP_W'(i_col) >= CMP_W'(i_cfg.col_start))
                 && (CMP_W'(i_col) < CMP_W'(i_cfg.col_end))
                 && (CMP_W'(i_row) >= CMP_W'(i_cfg.row_start))
                 && (CMP_W'(i_row) < CMP_W'(i_cfg.row_end));
        near = in_window && (depth_ext != '0) && (depth_ext < i_cfg.near_limit);
        n_count = r_count;
        n_min = r_min;
        if (near) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (depth_ext < r_min) begin
                n_min = depth_ext;
            end
        end
    end

    // the last pixel counts toward its own frame before the summary is taken
    assign o_sum.seen = (n_count > i_cfg.count_needed) && (i_cfg.near_limit != '0);
    assign o_sum.min_depth = n_min;
    assign o_sum.near_limit = i_cfg.near_limit;
    assign o_qw.push = accept && i_last_pixel;
    assign o_qw.full = i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min <= RST_NEAR_LIMIT;
        end else if (accept) begin
            if (i_last_pixel) begin
                r_count <= '0;
                r_min <= i_cfg.near_limit;
            end else begin
                r_count <= n_count;
                r_min <= n_min;
            end
        end
    end

endmodule

### design/dwop_queue.sv
// Two-entry queue of frame summaries between front and back.
// Depends on dwop_pkg.
module dwop_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dwop_pkg::t_q_wr      i_qw,
    input  dwop_pkg::t_frame_sum i_wdata,
    output logic                 o_full,
    input  dwop_pkg::t_q_rd      i_qr,
    output logic                 o_empty,
    output dwop_pkg::t_frame_sum o_rdata
);
    import dwop_pkg::*;

    t_frame_sum r_mem [2];
    logic r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_qw.push && !o_full;
    assign do_pop = i_qr.pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### design/dwop_back.sv
// Back end: turns a frame summary into a result, with a one bit per cycle
// restoring divider for the power term, and holds the output register.
// Depends on dwop_pkg and dwop_intf.
module dwop_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  dwop_pkg::t_frame_sum i_sum,
    output dwop_pkg::t_q_rd      o_qr,
    dwop_res_if.source           o_res
);
    import dwop_pkg::*;

    t_back_state r_state, n_state;
    logic r_seen, n_seen;
    logic [LIMIT_W-1:0] r_min, n_min;
    logic [NUM_W-1:0] r_rem, n_rem;
    logic [DSR_W-1:0] r_dsr, n_dsr;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [STEP_W-1:0] r_step, n_step;
    logic r_ov, n_ov;
    logic [LIMIT_W-1:0] r_odepth, n_odepth;
    logic [POWER_W-1:0] r_opower, n_opower;
    logic r_oseen, n_oseen;
    logic out_free, ge;
    logic [LIMIT_W-1:0] diff;

    assign out_free = !r_ov || o_res.ready;
    assign diff = i_sum.near_limit - i_sum.min_depth;
    assign ge = r_rem >= NUM_W'(r_dsr);

    always_comb begin
        n_state = r_state;
        n_seen = r_seen;
        n_min = r_min;
        n_rem = r_rem;
        n_dsr = r_dsr;
        n_quo = r_quo;
        n_step = r_step;
        n_ov = r_ov && !o_res.ready;
        n_odepth = r_odepth;
        n_opower = r_opower;
        n_oseen = r_oseen;
        o_qr.pop = 1'b0;
        o_qr.empty = i_q_empty;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_qr.pop = 1'b1;
                    n_seen = i_sum.seen;
                    n_min = i_sum.min_depth;
                    n_quo = '0;
                    n_rem = NUM_W'(POWER_SPAN) * NUM_W'(diff);
                    n_dsr = {i_sum.near_limit, {(QUO_W-1){1'b0}}};
                    n_step = STEP_W'(QUO_W - 1);
                    // minimum at or above the limit leaves the base power
                    if (i_sum.seen && (i_sum.min_depth < i_sum.near_limit)) begin
                        n_state = BK_DIV;
                    end else begin
                        n_state = BK_DONE;
                    end
                end
            end
            BK_DIV: begin
                if (ge) begin
                    n_rem = r_rem - NUM_W'(r_dsr);
                end
                n_quo = {r_quo[QUO_W-2:0], ge};
                n_dsr = r_dsr >> 1;
                n_step = r_step - 1'b1;
                if (r_step == '0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_oseen = r_seen;
                    n_odepth = r_seen ? r_min : '0;
                    n_opower = r_seen ? POWER_BASE + r_quo : '0;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seen <= n_seen;
        r_min <= n_min;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
        r_step <= n_step;
        r_odepth <= n_odepth;
        r_opower <= n_opower;
        r_oseen <= n_oseen;
    end

    assign o_res.valid = r_ov;
    assign o_res.nearest_depth = r_odepth;
    assign o_res.motor_power = r_opower;
    assign o_res.object_seen = r_oseen;

endmodule

### design/depth_window_obstacle_power.sv
// Top level: configuration registers, front end, summary queue, back end.
// Depends on dwop_pkg, dwop_intf, dwop_front, dwop_queue, dwop_back.
//
//  port      dir   kind           payload
//  i_pix     in    valid/ready    depth_raw, col, row, last_pixel
//  o_res     out   valid/ready    nearest_depth, motor_power, object_seen
//  psel...   in    APB write/read six registers at byte address 4*index
//
// One pixel is taken per cycle unless the queue is full. A frame's summary
// is queued with its last pixel, popped by the back end, run through the
// 7-step divider unless the divide is skipped, and written to the output
// register; the back end works on one frame while its output register holds
// another, the queue two more. Input stalls only when the queue is full;
// reset is synchronous and clears counters, queue and output valid.
module depth_window_obstacle_power (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dwop_pix_if.sink                      i_pix,
    dwop_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dwop_pkg::ADDR_W-1:0]   paddr,
    input  logic [dwop_pkg::DATA_W-1:0]   pwdata,
    output logic [dwop_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import dwop_pkg::*;

    t_cfg r_cfg;
    t_reg_idx reg_idx;
    logic wr_en;
    t_q_wr qw;
    t_q_rd qr;
    t_frame_sum sum_in, sum_out;
    logic q_full, q_empty;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit <= RST_NEAR_LIMIT;
            r_cfg.col_start <= RST_COL_START;
            r_cfg.col_end <= RST_COL_END;
            r_cfg.row_start <= RST_ROW_START;
            r_cfg.row_end <= RST_ROW_END;
            r_cfg.count_needed <= RST_COUNT_NEEDED;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NEAR_LIMIT: r_cfg.near_limit <= pwdata[LIMIT_W-1:0];
                REG_COL_START: r_cfg.col_start <= pwdata[CSTART_W-1:0];
                REG_COL_END: r_cfg.col_end <= pwdata[CEND_W-1:0];
                REG_ROW_START: r_cfg.row_start <= pwdata[CSTART_W-1:0];
                REG_ROW_END: r_cfg.row_end <= pwdata[CEND_W-1:0];
                REG_COUNT_NEEDED: r_cfg.count_needed <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEAR_LIMIT: prdata = DATA_W'(r_cfg.near_limit);
            REG_COL_START: prdata = DATA_W'(r_cfg.col_start);
            REG_COL_END: prdata = DATA_W'(r_cfg.col_end);
            REG_ROW_START: prdata = DATA_W'(r_cfg.row_start);
            REG_ROW_END: prdata = DATA_W'(r_cfg.row_end);
            REG_COUNT_NEEDED: prdata = DATA_W'(r_cfg.count_needed);
            default: prdata = '0;
        endcase
    end

    dwop_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_pix.valid),
        .o_ready      (i_pix.ready),
        .i_depth_raw  (i_pix.depth_raw),
        .i_col        (i_pix.col),
        .i_row        (i_pix.row),
        .i_last_pixel (i_pix.last_pixel),
        .o_qw         (qw),
        .i_q_full     (q_full),
        .o_sum        (sum_in)
    );

    dwop_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qw    (qw),
        .i_wdata (sum_in),
        .o_full  (q_full),
        .i_qr    (qr),
        .o_empty (q_empty),
        .o_rdata (sum_out)
    );

    dwop_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_sum     (sum_out),
        .o_qr      (qr),
        .o_res     (o_res)
    );

endmodule

### tb/sv/dwop_frame_checker.sv
`timescale 1ns / 1ps
// Scoreboard for depth_window_obstacle_power: follows pixel requests, result requests
// and the register port, predicts each frame result and compares it field by field.
// Depends on dwop_pkg and the stream interfaces in dwop_intf.
module dwop_frame_checker
    import dwop_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dwop_pix_if               i_pix,
    dwop_res_if               i_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    input  logic              i_drain_check,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_frames_checked,
    output int                o_obstacle_frames
);

    typedef struct packed {
        logic [LIMIT_W-1:0] nearest_depth;
        logic [POWER_W-1:0] motor_power;
        logic               object_seen;
    } t_frame_result;

    t_cfg               cfg;
    logic [COUNT_W-1:0] near_cnt;
    logic [LIMIT_W-1:0] min_depth;
    t_frame_result      frame_results_due[$];

    int fail_count = 0;
    int pending = 0;
    int frames_checked = 0;
    int obstacle_frames = 0;

    assign o_fail_count = fail_count;
    assign o_pending = pending;
    assign o_frames_checked = frames_checked;
    assign o_obstacle_frames = obstacle_frames;

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40) begin
            $display("[%0t] MISMATCH %s", $time, what);
        end
    endtask

    function automatic logic [POWER_W-1:0] motor_duty(logic [LIMIT_W-1:0] limit,
                                                      logic [LIMIT_W-1:0] nearest);
        int unsigned gap;
        // nearest can sit at or above the limit only if the limit dropped mid-frame
        if (nearest >= limit) return POWER_BASE;
        gap = limit - nearest;
        return POWER_BASE + POWER_W'((POWER_SPAN * gap) / limit);
    endfunction

    function automatic t_frame_result close_frame(logic [COUNT_W-1:0] cnt,
                                                  logic [LIMIT_W-1:0] nearest, t_cfg c);
        t_frame_result r;
        r = '0;
        if (cnt > c.count_needed && c.near_limit != '0) begin
            r.nearest_depth = nearest;
            r.motor_power = motor_duty(c.near_limit, nearest);
            r.object_seen = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] reg_value(logic [ADDR_W-1:0] addr);
        case (t_reg_idx'(addr[ADDR_W-1:2]))
            REG_NEAR_LIMIT:   return DATA_W'(cfg.near_limit);
            REG_COL_START:    return DATA_W'(cfg.col_start);
            REG_COL_END:      return DATA_W'(cfg.col_end);
            REG_ROW_START:    return DATA_W'(cfg.row_start);
            REG_ROW_END:      return DATA_W'(cfg.row_end);
            REG_COUNT_NEEDED: return DATA_W'(cfg.count_needed);
            default:          return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result got;
        if (!i_rst_n) begin
            cfg = '{RST_NEAR_LIMIT, RST_COL_START, RST_COL_END,
                    RST_ROW_START, RST_ROW_END, RST_COUNT_NEEDED};
            near_cnt = '0;
            min_depth = RST_NEAR_LIMIT;
            frame_results_due.delete();
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                if (i_pix.col >= cfg.col_start && i_pix.col < cfg.col_end &&
                    i_pix.row >= cfg.row_start && i_pix.row < cfg.row_end &&
                    i_pix.depth_raw != '0 && i_pix.depth_raw < cfg.near_limit) begin
                    if (near_cnt != COUNT_MAX) near_cnt++;
                    if (i_pix.depth_raw < min_depth) min_depth = i_pix.depth_raw;
                end
                // last pixel is counted first, then the frame closes
                if (i_pix.last_pixel) begin
                    frame_results_due.push_back(close_frame(near_cnt, min_depth, cfg));
                    near_cnt = '0;
                    min_depth = cfg.near_limit;
                end
            end

            if (i_res.valid && i_res.ready) begin
                got = '{i_res.nearest_depth, i_res.motor_power, i_res.object_seen};
                if (frame_results_due.size() == 0) begin
                    report_mismatch($sformatf("result request with no frame waiting: %p", got));
                end else begin
                    want = frame_results_due.pop_front();
                    frames_checked++;
                    if (want.object_seen) obstacle_frames++;
                    if (got.nearest_depth !== want.nearest_depth)
                        report_mismatch($sformatf("frame %0d nearest_depth %0d, expected %0d",
                            frames_checked, got.nearest_depth, want.nearest_depth));
                    if (got.motor_power !== want.motor_power)
                        report_mismatch($sformatf("frame %0d motor_power %0d, expected %0d",
                            frames_checked, got.motor_power, want.motor_power));
                    if (got.object_seen !== want.object_seen)
                        report_mismatch($sformatf("frame %0d object_seen %0b, expected %0b",
                            frames_checked, got.object_seen, want.object_seen));
                end
            end

            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[ADDR_W-1:2]))
                        REG_NEAR_LIMIT:   cfg.near_limit = pwdata[LIMIT_W-1:0];
                        REG_COL_START:    cfg.col_start = pwdata[CSTART_W-1:0];
                        REG_COL_END:      cfg.col_end = pwdata[CEND_W-1:0];
                        REG_ROW_START:    cfg.row_start = pwdata[CSTART_W-1:0];
                        REG_ROW_END:      cfg.row_end = pwdata[CEND_W-1:0];
                        REG_COUNT_NEEDED: cfg.count_needed = pwdata[COUNT_W-1:0];
                        default: ;
                    endcase
                end else if (prdata !== reg_value(paddr)) begin
                    report_mismatch($sformatf("register read at 0x%0h gave 0x%0h, expected 0x%0h",
                        paddr, prdata, reg_value(paddr)));
                end
            end

            if (i_drain_check && frame_results_due.size() != 0) begin
                report_mismatch($sformatf("%0d frame results never arrived",
                    frame_results_due.size()));
                frame_results_due.delete();
            end
        end
        pending = frame_results_due.size();
    end

endmodule

### tb/sv/tb_depth_window_obstacle_power.sv
`timescale 1ns / 1ps
// Top of the depth_window_obstacle_power testbench: clock, reset, register setup,
// pixel stimulus and result back-pressure. Checking lives in dwop_frame_checker.
// Depends on dwop_pkg, dwop_intf, the block and the checker.
module tb_depth_window_obstacle_power;
    import dwop_pkg::*;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic                  last;
    } t_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              drain_check = 1'b0;

    int fail_count;
    int results_pending;
    int frames_checked;
    int obstacle_frames;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_results = 1'b0;
    int   pixels_sent = 0;
    int   settings_applied = 0;
    t_cfg cur_cfg;

    dwop_pix_if pix_ch ();
    dwop_res_if res_ch ();

    depth_window_obstacle_power dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dwop_frame_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pix             (pix_ch),
        .i_res             (res_ch),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_drain_check     (drain_check),
        .o_fail_count      (fail_count),
        .o_pending         (results_pending),
        .o_frames_checked  (frames_checked),
        .o_obstacle_frames (obstacle_frames)
    );

    always #6 i_clk = ~i_clk;

    // result side: random stalls, or a long hold-off when asked
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= !hold_results && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic apb_access(input logic write, input t_reg_idx r,
                              input logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= ADDR_W'({r, 2'b00});
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        apb_access(1'b1, REG_NEAR_LIMIT, DATA_W'(c.near_limit));
        apb_access(1'b1, REG_COL_START, DATA_W'(c.col_start));
        apb_access(1'b1, REG_COL_END, DATA_W'(c.col_end));
        apb_access(1'b1, REG_ROW_START, DATA_W'(c.row_start));
        apb_access(1'b1, REG_ROW_END, DATA_W'(c.row_end));
        apb_access(1'b1, REG_COUNT_NEEDED, DATA_W'(c.count_needed));
        apb_access(1'b0, REG_NEAR_LIMIT, '0);
        apb_access(1'b0, REG_COL_START, '0);
        apb_access(1'b0, REG_COL_END, '0);
        apb_access(1'b0, REG_ROW_START, '0);
        apb_access(1'b0, REG_ROW_END, '0);
        apb_access(1'b0, REG_COUNT_NEEDED, '0);
        cur_cfg = c;
        settings_applied++;
    endtask

    // entered and left on a falling edge; valid stays up into the next request
    task automatic send_pixel(input t_pixel p);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.depth_raw <= p.depth;
        pix_ch.col <= p.col;
        pix_ch.row <= p.row;
        pix_ch.last_pixel <= p.last;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    // drop valid, let all frame results drain, then allow the divider to go quiet
    task automatic settle();
        pix_ch.valid <= 1'b0;
        wait (results_pending == 0);
        repeat (16) @(negedge i_clk);
    endtask

    function automatic logic [COORD_BITS-1:0] pick_coord(int lo, int hi);
        int r;
        r = $urandom_range(99);
        if (r < 15) return COORD_BITS'($urandom);
        if (r < 35) begin
            case ($urandom_range(3))
                0:       return COORD_BITS'(lo - 1);
                1:       return COORD_BITS'(lo);
                2:       return COORD_BITS'(hi - 1);
                default: return COORD_BITS'(hi);
            endcase
        end
        if (hi > lo) return COORD_BITS'($urandom_range(hi - 1, lo));
        return COORD_BITS'($urandom);
    endfunction

    function automatic logic [DEPTH_BITS-1:0] pick_depth(int limit);
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 25) begin
            case ($urandom_range(4))
                0:       return DEPTH_BITS'(limit - 1);
                1:       return DEPTH_BITS'(limit);
                2:       return DEPTH_BITS'(limit + 1);
                3:       return DEPTH_BITS'(1);
                default: return '1;
            endcase
        end
        if (r < 75 && limit > 1) return DEPTH_BITS'($urandom_range(limit - 1, 1));
        return DEPTH_BITS'($urandom);
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_pixel('{pick_depth(cur_cfg.near_limit),
                         pick_coord(cur_cfg.col_start, cur_cfg.col_end),
                         pick_coord(cur_cfg.row_start, cur_cfg.row_end),
                         i == len - 1});
        end
    endtask

    function automatic int random_frame_len();
        if ($urandom_range(9) == 0) return $urandom_range(120, 60);
        return $urandom_range(30, 1);
    endfunction

    function automatic int window_end(int start);
        int r;
        r = $urandom_range(9);
        if (r == 0) return $urandom_range(start, 0);   // empty window
        if (r < 3) return 2048;
        return (start + $urandom_range(700, 1) > 2048) ? 2048 : start + $urandom_range(700, 1);
    endfunction

    function automatic t_cfg random_setting();
        t_cfg c;
        case ($urandom_range(5))
            0:       c.near_limit = '1;
            1:       c.near_limit = LIMIT_W'($urandom_range(65535, 1));
            default: c.near_limit = LIMIT_W'($urandom_range(8000, 200));
        endcase
        c.col_start = ($urandom_range(4) == 0) ? '0 : CSTART_W'($urandom_range(2047));
        c.col_end = CEND_W'(window_end(c.col_start));
        c.row_start = ($urandom_range(4) == 0) ? '0 : CSTART_W'($urandom_range(2047));
        c.row_end = CEND_W'(window_end(c.row_start));
        c.count_needed = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(4194304))
                                                  : COUNT_W'($urandom_range(6));
        return c;
    endfunction

    initial begin
        int target;
        pix_ch.valid = 1'b0;
        pix_ch.depth_raw = '0;
        pix_ch.col = '0;
        pix_ch.row = '0;
        pix_ch.last_pixel = 1'b0;
        cur_cfg = '{RST_NEAR_LIMIT, RST_COL_START, RST_COL_END,
                    RST_ROW_START, RST_ROW_END, RST_COUNT_NEEDED};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: nearest possible depth, zero depth, edges of the frame
        send_pixel('{16'd1, 11'd0, 11'd0, 1'b1});
        send_pixel('{16'd0, 11'd0, 11'd0, 1'b1});
        send_pixel('{16'd1999, 11'd2047, 11'd2047, 1'b0});
        send_pixel('{16'd2000, 11'd5, 11'd5, 1'b0});
        send_pixel('{16'hFFFF, 11'd0, 11'd2047, 1'b1});
        // limit lowered below the running minimum in the middle of a frame
        send_pixel('{16'd1500, 11'd100, 11'd100, 1'b0});
        settle();
        apb_access(1'b1, REG_NEAR_LIMIT, DATA_W'(1000));
        cur_cfg.near_limit = 16'd1000;
        send_pixel('{16'd0, 11'd100, 11'd100, 1'b1});
        settle();
        // one-pixel window in the far corner, widest limit
        apply_config('{16'hFFFF, 11'd2047, 12'd2048, 11'd2047, 12'd2048, 23'd0});
        send_pixel('{16'hFFFE, 11'd2047, 11'd2047, 1'b0});
        send_pixel('{16'd1, 11'd2046, 11'd2047, 1'b0});
        send_pixel('{16'd1, 11'd2047, 11'd2046, 1'b1});
        settle();
        // empty column range
        apply_config('{16'd3000, 11'd5, 12'd5, 11'd0, 12'd2048, 23'd0});
        send_pixel('{16'd10, 11'd5, 11'd5, 1'b0});
        send_pixel('{16'd10, 11'd4, 11'd7, 1'b1});
        settle();
        // zero limit: nothing can be near
        apply_config('{16'd0, 11'd0, 12'd2048, 11'd0, 12'd2048, 23'd0});
        send_pixel('{16'd1, 11'd3, 11'd3, 1'b0});
        send_pixel('{16'd2, 11'd3, 11'd4, 1'b1});
        settle();
        // threshold set far above the frame's pixel count
        apply_config('{16'd5000, 11'd0, 12'd2048, 11'd0, 12'd2048, 23'd4194304});
        send_pixel('{16'd7, 11'd9, 11'd9, 1'b0});
        send_pixel('{16'd8, 11'd9, 11'd10, 1'b1});
        settle();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0)
                apply_config('{16'hFFFF, 11'd0, 12'd2048, 11'd0, 12'd2048, 23'd0});
            else
                apply_config(random_setting());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            target = pixels_sent + 115;
            while (pixels_sent < target) send_frame(random_frame_len());
            settle();
        end

        // results held off for a long stretch while short frames keep coming
        apply_config(random_setting());
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                @(posedge i_clk);
                hold_results = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_results = 1'b0;
            end
        join_none
        repeat (40) send_frame($urandom_range(3, 1));
        settle();

        // sender waits for every frame result before the next frame
        apply_config(random_setting());
        send_idle_pct = 6;
        recv_stall_pct = 6;
        repeat (10) begin
            send_frame(random_frame_len());
            settle();
        end

        for (int w = 0; w < 5000 && results_pending != 0; w++) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
        drain_check <= 1'b1;
        @(negedge i_clk);
        drain_check <= 1'b0;
        @(negedge i_clk);

        $display("Run covered %0d pixel requests under %0d register settings.",
                 pixels_sent, settings_applied);
        $display("%0d frame results checked, %0d of them reporting an obstacle.",
                 frames_checked, obstacle_frames);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### depth_window_obstacle_power.f
design/dwop_pkg.sv
design/dwop_intf.sv
design/dwop_front.sv
design/dwop_queue.sv
design/dwop_back.sv
design/depth_window_obstacle_power.sv
tb/sv/dwop_frame_checker.sv
tb/sv/tb_depth_window_obstacle_power.sv
